>>> rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants
// Configuration layout, per-button state record and result beat for the
// button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int FIELD_BITS      = 4;
    localparam int TIME_W          = 32;
    localparam int MS16_W          = 16;
    localparam int WIN_W           = 22;
    localparam int CNT_W           = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE,
        CFG_LONG_PRESS,
        CFG_ACTIVE_LOW,
        CFG_MIN_INTERVAL,
        CFG_WINDOW,
        CFG_MAX_PER_WINDOW
    } t_cfg_idx;

    typedef struct packed {
        logic [MS16_W-1:0] debounce_ms;
        logic [MS16_W-1:0] long_press_ms;
        logic              active_low;
        logic [MS16_W-1:0] min_interval_ms;
        logic [WIN_W-1:0]  window_ms;
        logic [CNT_W-1:0]  max_per_window;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        debounce_ms:     16'd50,
        long_press_ms:   16'd2000,
        active_low:      1'b1,
        min_interval_ms: 16'd500,
        window_ms:       22'd60000,
        max_per_window:  8'd10
    };

    typedef struct packed {
        logic              prev_raw;
        logic              stable;
        logic              press_active;
        logic              long_done;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_begin;
        logic [TIME_W-1:0] last_accept;
        logic [TIME_W-1:0] window_begin;
        logic [CNT_W-1:0]  window_count;
    } t_btn_state;

    // idle level follows the polarity in force at reset (active low)
    localparam t_btn_state BTN_RESET = '{
        prev_raw:     1'b1,
        stable:       1'b1,
        press_active: 1'b0,
        long_done:    1'b0,
        change_time:  '0,
        press_begin:  '0,
        last_accept:  '0,
        window_begin: '0,
        window_count: '0
    };

    typedef struct packed {
        logic deb_ok;
        logic hold_short;
        logic long_zero;
        logic int_fail;
        logic win_exp;
        logic cnt_full;
        logic max_zero;
    } t_flags;

    typedef struct packed {
        logic [FIELD_BITS-1:0] short_fire;
        logic [FIELD_BITS-1:0] long_fire;
        logic [FIELD_BITS-1:0] suppressed;
        logic [FIELD_BITS-1:0] held;
    } t_result;

endpackage

>>> rtl/bpc_ram.sv
// ----------------------------------------------------------------------------
// bpc_ram: generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bpc_pipe.sv
// ----------------------------------------------------------------------------
// bpc_pipe: per-button read-modify-write pipeline
// Walks the buttons of one sample through the state RAM: read, compute time
// differences, then debounce / press / limiter decisions and write back.
// ----------------------------------------------------------------------------
module bpc_pipe
    import bpc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_start,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [FIELD_BITS-1:0] i_levels,
    output logic                  o_free,
    output logic                  o_push,
    output t_result               o_result
);

    localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [BW-1:0] LAST_B = BW'(NUM_BUTTONS - 1);

    // issue stage
    logic                  r_busy;
    logic [BW-1:0]         r_b;
    logic [TIME_W-1:0]     r_now;
    logic [FIELD_BITS-1:0] r_levels;
    logic                  issue_hit;
    logic                  issue_go;
    logic                  issue_last;
    logic                  issue_raw;

    // read stage
    logic                  r_s1_v;
    logic [BW-1:0]         r_s1_b;
    logic [TIME_W-1:0]     r_s1_now;
    logic                  r_s1_raw;
    logic                  r_s1_last;
    logic                  r_s1_init;
    logic [$bits(t_btn_state)-1:0] ram_rdata;
    t_btn_state            st1;
    t_flags                fl1;
    logic                  raw_chg;

    // update stage
    logic                  r_s2_v;
    logic [BW-1:0]         r_s2_b;
    logic [TIME_W-1:0]     r_s2_now;
    logic                  r_s2_raw;
    logic                  r_s2_last;
    t_btn_state            r_s2_st;
    t_flags                r_s2_fl;
    t_btn_state            st2;
    logic                  pressed;
    logic                  fresh;
    logic                  ev_short;
    logic                  ev_long;
    logic                  ev_ok;
    t_result               cur;
    t_result               r_acc;

    logic [NUM_BUTTONS-1:0] r_valid;

    // interlock: entry still in flight in a later stage
    assign issue_hit  = (r_s1_v && (r_s1_b == r_b)) || (r_s2_v && (r_s2_b == r_b));
    assign issue_go   = r_busy && !issue_hit;
    assign issue_last = (r_b == LAST_B);
    assign o_free     = !r_busy || (issue_go && issue_last);

    always_comb begin
        issue_raw = 1'b0;
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (int'(r_b) == i) begin
                issue_raw = r_levels[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_b    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_b    <= '0;
        end else if (issue_go && issue_last) begin
            r_busy <= 1'b0;
        end else if (issue_go) begin
            r_b <= r_b + BW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_now    <= i_now_ms;
            r_levels <= i_levels;
        end
    end

    bpc_ram #(
        .WIDTH ($bits(t_btn_state)),
        .DEPTH (NUM_BUTTONS),
        .AW    (BW)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s2_v),
        .i_wr_addr (r_s2_b),
        .i_wr_data (st2),
        .i_rd_en   (issue_go),
        .i_rd_addr (r_b),
        .o_rd_data (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= issue_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_go) begin
            r_s1_b    <= r_b;
            r_s1_now  <= r_now;
            r_s1_raw  <= issue_raw;
            r_s1_last <= issue_last;
            r_s1_init <= r_valid[r_b];
        end
    end

    // read stage: time differences and compares
    always_comb begin
        st1     = r_s1_init ? t_btn_state'(ram_rdata) : BTN_RESET;
        raw_chg = (r_s1_raw != st1.prev_raw);
        fl1.deb_ok     = !raw_chg &&
                         ((r_s1_now - st1.change_time) > TIME_W'(i_cfg.debounce_ms));
        fl1.hold_short = (r_s1_now - st1.press_begin) < TIME_W'(i_cfg.long_press_ms);
        fl1.long_zero  = (i_cfg.long_press_ms == '0);
        fl1.int_fail   = (r_s1_now - st1.last_accept) < TIME_W'(i_cfg.min_interval_ms);
        fl1.win_exp    = (r_s1_now - st1.window_begin) >= TIME_W'(i_cfg.window_ms);
        fl1.cnt_full   = (st1.window_count >= i_cfg.max_per_window);
        fl1.max_zero   = (i_cfg.max_per_window == '0);
        if (raw_chg) begin
            st1.change_time = r_s1_now;
        end
        st1.prev_raw = r_s1_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2_b    <= r_s1_b;
            r_s2_now  <= r_s1_now;
            r_s2_raw  <= r_s1_raw;
            r_s2_last <= r_s1_last;
            r_s2_st   <= st1;
            r_s2_fl   <= fl1;
        end
    end

    // update stage: debounce, press tracking, limiter
    always_comb begin
        st2      = r_s2_st;
        pressed  = r_s2_raw ^ i_cfg.active_low;
        fresh    = 1'b0;
        ev_short = 1'b0;
        ev_long  = 1'b0;
        ev_ok    = 1'b0;
        cur      = '0;
        if (r_s2_fl.deb_ok && (r_s2_raw != r_s2_st.stable)) begin
            st2.stable = r_s2_raw;
            if (pressed && !r_s2_st.press_active) begin
                st2.press_active = 1'b1;
                st2.long_done    = 1'b0;
                st2.press_begin  = r_s2_now;
                fresh            = 1'b1;
            end else if (!pressed && r_s2_st.press_active) begin
                st2.press_active = 1'b0;
                if (!r_s2_st.long_done && r_s2_fl.hold_short) begin
                    ev_short = 1'b1;
                end
            end
        end
        if (st2.press_active && !st2.long_done &&
            (fresh ? r_s2_fl.long_zero : !r_s2_fl.hold_short)) begin
            st2.long_done = 1'b1;
            ev_long       = 1'b1;
        end
        if ((ev_short || ev_long) && !r_s2_fl.int_fail) begin
            if (r_s2_fl.win_exp) begin
                st2.window_begin = r_s2_now;
                st2.window_count = '0;
            end
            if (!(r_s2_fl.win_exp ? r_s2_fl.max_zero : r_s2_fl.cnt_full)) begin
                st2.last_accept  = r_s2_now;
                st2.window_count = st2.window_count + CNT_W'(1);
                ev_ok            = 1'b1;
            end
        end
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (int'(r_s2_b) == i) begin
                cur.short_fire[i] = ev_short && ev_ok;
                cur.long_fire[i]  = ev_long && ev_ok;
                cur.suppressed[i] = (ev_short || ev_long) && !ev_ok;
                cur.held[i]       = st2.press_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_acc   <= '0;
        end else if (r_s2_v) begin
            r_valid[r_s2_b] <= 1'b1;
            r_acc           <= r_s2_last ? t_result'('0) : t_result'(r_acc | cur);
        end
    end

    assign o_push   = r_s2_v && r_s2_last;
    assign o_result = t_result'(r_acc | cur);

    a_stage_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s2_v) |-> (r_s1_b != r_s2_b))
        else $error("read and update stages hold the same button");

    a_valid_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |=> r_valid[$past(r_s2_b)])
        else $error("entry not marked valid after write back");

endmodule

>>> rtl/bpc_outq.sv
// ----------------------------------------------------------------------------
// bpc_outq: two-entry result queue
// Holds finished result beats so the pipeline keeps running while the
// receiver stalls.
// ----------------------------------------------------------------------------
module bpc_outq
    import bpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push)
        else $error("result pushed into full queue");

endmodule

>>> rtl/button_press_classifier_top.sv
// ----------------------------------------------------------------------------
// button_press_classifier_top: debounce, short/long press and rate limiter
// Input beat: i_now_ms and i_button_levels, taken on i_in_valid & o_in_ready.
// Output beat: one per input beat with o_short_fire, o_long_fire,
// o_suppressed and o_held, taken on o_out_valid & i_out_ready.
// Config beat: i_cfg_index / i_cfg_data on i_cfg_valid & o_cfg_ready; the
// port is always ready, unknown indexes are dropped. Write only when idle.
// Per-button state lives in one RAM; the pipeline issues a read for one
// button a cycle unless the same-button interlock holds it, computes time
// differences in the read stage and writes back from the update stage.
// A new input beat is taken once the last button of the previous one has
// issued; the single RAM read port, the interlock and the two-beat
// outstanding limit set the input rate.
// Reset: config to defaults, all buttons idle, no beats in flight; the RAM
// needs no clearing, per-entry valid bits supply the idle state.
// Stall: up to two results queue; input is held off once two beats are
// outstanding, and nothing is dropped.
// ----------------------------------------------------------------------------
module button_press_classifier_top
    import bpc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [FIELD_BITS-1:0] i_button_levels,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [FIELD_BITS-1:0] o_short_fire,
    output logic [FIELD_BITS-1:0] o_long_fire,
    output logic [FIELD_BITS-1:0] o_suppressed,
    output logic [FIELD_BITS-1:0] o_held,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic [1:0] r_outst;
    logic       pipe_free;
    logic       in_fire;
    logic       out_fire;
    logic       push;
    t_result    push_data;
    t_result    out_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = pipe_free && (r_outst != 2'd2);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE:       r_cfg.debounce_ms     <= i_cfg_data[MS16_W-1:0];
                CFG_LONG_PRESS:     r_cfg.long_press_ms   <= i_cfg_data[MS16_W-1:0];
                CFG_ACTIVE_LOW:     r_cfg.active_low      <= i_cfg_data[0];
                CFG_MIN_INTERVAL:   r_cfg.min_interval_ms <= i_cfg_data[MS16_W-1:0];
                CFG_WINDOW:         r_cfg.window_ms       <= i_cfg_data[WIN_W-1:0];
                CFG_MAX_PER_WINDOW: r_cfg.max_per_window  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= 2'd0;
        end else if (in_fire && !out_fire) begin
            r_outst <= r_outst + 2'd1;
        end else if (!in_fire && out_fire) begin
            r_outst <= r_outst - 2'd1;
        end
    end

    bpc_pipe #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (in_fire),
        .i_now_ms (i_now_ms),
        .i_levels (i_button_levels),
        .o_free   (pipe_free),
        .o_push   (push),
        .o_result (push_data)
    );

    bpc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_short_fire = out_data.short_fire;
    assign o_long_fire  = out_data.long_fire;
    assign o_suppressed = out_data.suppressed;
    assign o_held       = out_data.held;

    a_outst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outst == 2'd0) |-> !o_out_valid)
        else $error("result beat with no input beat outstanding");

endmodule

>>> tb/sv/tb_button_press_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_button_press_classifier_top: self-checking bench for the press classifier
// Drives timestamped button samples through the input channel and scores
// every result beat against a cycle-free software copy of the debouncer,
// press timer and per-button rate limiter. Directed sequences cover reset
// defaults, limiter start-up, field extremes, register masking, spare
// register indexes and live polarity changes. Random phases follow at
// several settings, including time wrap and the register extremes, with
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_top
    import bpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB       = NUM_BUTTONS_DEF;
    localparam int SETTLE   = 2 * (NB + 3);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic [FIELD_BITS-1:0] i_button_levels = '1;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [FIELD_BITS-1:0] o_short_fire;
    logic [FIELD_BITS-1:0] o_long_fire;
    logic [FIELD_BITS-1:0] o_suppressed;
    logic [FIELD_BITS-1:0] o_held;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    button_press_classifier_top DUT (.*);

    // shadow of the register file
    logic [MS16_W-1:0] cfg_debounce;
    logic [MS16_W-1:0] cfg_long;
    logic              cfg_active_low;
    logic [MS16_W-1:0] cfg_min_gap;
    logic [WIN_W-1:0]  cfg_window;
    logic [CNT_W-1:0]  cfg_max;

    typedef struct {
        logic              prev_raw;
        logic              stable;
        logic              active;
        logic              long_done;
        logic [TIME_W-1:0] change_ms;
        logic [TIME_W-1:0] press_ms;
        logic [TIME_W-1:0] last_ok_ms;
        logic [TIME_W-1:0] win_start;
        logic [CNT_W-1:0]  win_count;
    } t_btn_track;

    t_btn_track btn [NB];
    t_result    pending_results[$];

    bit  jitter_on = 1'b1;
    int  sink_hold_req = 0;
    int  fail_count = 0;
    int  n_samples = 0;
    int  n_results = 0;
    int  n_short = 0;
    int  n_long = 0;
    int  n_supp = 0;

    logic [TIME_W-1:0]     ms_now = '0;
    logic [FIELD_BITS-1:0] cur_lv = '1;
    int                    seg_left [NB];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic void reset_shadow();
        cfg_debounce   = 16'd50;
        cfg_long       = 16'd2000;
        cfg_active_low = 1'b1;
        cfg_min_gap    = 16'd500;
        cfg_window     = 22'd60000;
        cfg_max        = 8'd10;
        for (int b = 0; b < NB; b++) begin
            btn[b].prev_raw   = cfg_active_low;
            btn[b].stable     = cfg_active_low;
            btn[b].active     = 1'b0;
            btn[b].long_done  = 1'b0;
            btn[b].change_ms  = '0;
            btn[b].press_ms   = '0;
            btn[b].last_ok_ms = '0;
            btn[b].win_start  = '0;
            btn[b].win_count  = '0;
            seg_left[b]       = 0;
        end
    endfunction

    function automatic void shadow_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE:       cfg_debounce   = data[MS16_W-1:0];
            CFG_LONG_PRESS:     cfg_long       = data[MS16_W-1:0];
            CFG_ACTIVE_LOW:     cfg_active_low = data[0];
            CFG_MIN_INTERVAL:   cfg_min_gap    = data[MS16_W-1:0];
            CFG_WINDOW:         cfg_window     = data[WIN_W-1:0];
            CFG_MAX_PER_WINDOW: cfg_max        = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic bit rate_gate(int b, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since_ok;
        logic [TIME_W-1:0] win_age;
        since_ok = now - btn[b].last_ok_ms;
        if (since_ok < cfg_min_gap)
            return 1'b0;
        win_age = now - btn[b].win_start;
        if (win_age >= cfg_window) begin
            btn[b].win_start = now;
            btn[b].win_count = '0;
        end
        if (btn[b].win_count >= cfg_max)
            return 1'b0;
        btn[b].last_ok_ms = now;
        btn[b].win_count  = btn[b].win_count + CNT_W'(1);
        return 1'b1;
    endfunction

    function automatic t_result classify_sample(logic [TIME_W-1:0] now,
                                                logic [FIELD_BITS-1:0] levels);
        t_result           r;
        logic              raw;
        logic              pressed;
        logic [TIME_W-1:0] stable_for;
        logic [TIME_W-1:0] held_for;
        r = '0;
        for (int b = 0; b < NB; b++) begin
            raw = levels[b];
            if (raw != btn[b].prev_raw)
                btn[b].change_ms = now;
            stable_for = now - btn[b].change_ms;
            if (stable_for > cfg_debounce && raw != btn[b].stable) begin
                pressed = cfg_active_low ? !raw : raw;
                btn[b].stable = raw;
                if (pressed && !btn[b].active) begin
                    btn[b].active    = 1'b1;
                    btn[b].long_done = 1'b0;
                    btn[b].press_ms  = now;
                end else if (!pressed && btn[b].active) begin
                    btn[b].active = 1'b0;
                    held_for = now - btn[b].press_ms;
                    if (!btn[b].long_done && held_for < cfg_long) begin
                        if (rate_gate(b, now))
                            r.short_fire[b] = 1'b1;
                        else
                            r.suppressed[b] = 1'b1;
                    end
                end
            end
            held_for = now - btn[b].press_ms;
            if (btn[b].active && !btn[b].long_done && held_for >= cfg_long) begin
                btn[b].long_done = 1'b1;
                if (rate_gate(b, now))
                    r.long_fire[b] = 1'b1;
                else
                    r.suppressed[b] = 1'b1;
            end
            btn[b].prev_raw = raw;
            r.held[b] = btn[b].active;
        end
        return r;
    endfunction

    // ---------------- channel drivers ----------------

    function automatic int draw_gap();
        int r;
        if (!jitter_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_sample(input logic [TIME_W-1:0] now, input logic [FIELD_BITS-1:0] lv);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_now_ms        <= now;
        i_button_levels <= lv;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_results.push_back(classify_sample(now, lv));
        n_samples++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        shadow_reg(idx, data);
    endtask

    task automatic set_config(input int deb, input int lp, input bit al, input int gap,
                              input int win, input int mx);
        drain();
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(CFG_LONG_PRESS, CFG_DATA_W'(lp));
        write_reg(CFG_ACTIVE_LOW, CFG_DATA_W'(al));
        write_reg(CFG_MIN_INTERVAL, CFG_DATA_W'(gap));
        write_reg(CFG_WINDOW, CFG_DATA_W'(win));
        write_reg(CFG_MAX_PER_WINDOW, CFG_DATA_W'(mx));
        i_cfg_valid <= 1'b0;
    endtask

    // output side: random stalls, or a long hold on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req > 0) begin
                n = sink_hold_req;
                sink_hold_req = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                n = draw_gap();
            end else begin
                n = 0;
            end
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [FIELD_BITS-1:0] exp_v,
                               input logic [FIELD_BITS-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    initial begin
        t_result exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    check_field("short_fire", exp_r.short_fire, o_short_fire);
                    check_field("long_fire", exp_r.long_fire, o_long_fire);
                    check_field("suppressed", exp_r.suppressed, o_suppressed);
                    check_field("held", exp_r.held, o_held);
                    n_short += $countones(o_short_fire);
                    n_long  += $countones(o_long_fire);
                    n_supp  += $countones(o_suppressed);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        // press and release before the first interval has elapsed, then a long press
        send_sample(32'd0, 4'hF);
        send_sample(32'd10, 4'hE);
        send_sample(32'd61, 4'hE);
        send_sample(32'd100, 4'hF);
        send_sample(32'd151, 4'hF);
        send_sample(32'd600, 4'hE);
        send_sample(32'd651, 4'hE);
        send_sample(32'd2651, 4'hE);
        send_sample(32'd2700, 4'hF);
        send_sample(32'd2751, 4'hF);
        send_sample(32'd3300, 4'h0);
        send_sample(32'd3351, 4'h0);
        send_sample(32'd3400, 4'hF);
        send_sample(32'd3451, 4'hF);
        drain();
    endtask

    task automatic test_field_extremes();
        send_sample(32'hFFFF_FFFF, 4'hF);
        send_sample(32'h0000_0000, 4'h0);
        send_sample(32'h7FFF_FFFF, 4'h0);
        send_sample(32'hFFFF_FFF0, 4'hF);
        drain();
    endtask

    task automatic test_register_masks();
        drain();
        write_reg(CFG_DEBOUNCE, 22'h3F_0003);
        write_reg(CFG_LONG_PRESS, 22'h2A_0064);
        write_reg(CFG_ACTIVE_LOW, 22'h3F_FFFE);
        write_reg(CFG_MIN_INTERVAL, 22'h3F_0000);
        write_reg(CFG_WINDOW, 22'h3F_FFFF);
        write_reg(CFG_MAX_PER_WINDOW, 22'h3F_FF02);
        write_reg(CFG_IDX_SPARE_LO, 22'h00_0000);
        write_reg(CFG_IDX_SPARE_HI, 22'h3F_FFFF);
        i_cfg_valid <= 1'b0;
        send_sample(32'd10000, 4'h0);
        send_sample(32'd10004, 4'h5);
        send_sample(32'd10009, 4'h5);
        send_sample(32'd10020, 4'h0);
        send_sample(32'd10030, 4'h0);
        drain();
    endtask

    task automatic test_polarity_live();
        set_config(2, 500, 1, 0, 1000, 8);
        send_sample(32'd20000, 4'hF);
        send_sample(32'd20005, 4'hD);
        send_sample(32'd20010, 4'hD);
        set_config(2, 500, 0, 0, 1000, 8);
        send_sample(32'd20020, 4'hF);
        send_sample(32'd20030, 4'hD);
        send_sample(32'd20040, 4'hD);
        drain();
        ms_now = 32'd20040;
        cur_lv = 4'hD;
    endtask

    // level runs per button with bounces, noise and the odd large time jump
    task automatic run_random_phase(input int n, input int dt_max);
        logic [FIELD_BITS-1:0] lv;
        for (int k = 0; k < n; k++) begin
            for (int b = 0; b < NB; b++) begin
                if (seg_left[b] == 0) begin
                    cur_lv[b] = ~cur_lv[b];
                    seg_left[b] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                               : $urandom_range(3, 40);
                end
                seg_left[b]--;
            end
            lv = cur_lv;
            if ($urandom_range(0, 19) == 0)
                lv = FIELD_BITS'($urandom_range(0, 15));
            if ($urandom_range(0, 49) == 0)
                ms_now = ms_now + $urandom;
            else
                ms_now = ms_now + $urandom_range(0, dt_max);
            send_sample(ms_now, lv);
        end
    endtask

    task automatic test_random_typical();
        set_config(5, 150, 1, 20, 400, 3);
        run_random_phase(200, 15);
        jitter_on = 1'b0;
        set_config(0, 60, 0, 0, 100, 1);
        run_random_phase(150, 12);
        jitter_on = 1'b1;
    endtask

    task automatic test_register_extremes();
        set_config(0, 0, 1, 0, 0, 255);
        run_random_phase(120, 10);
        set_config(65535, 65535, 0, 65535, 3600000, 0);
        run_random_phase(120, 20000);
    endtask

    task automatic test_time_wrap();
        drain();
        ms_now = 32'hFFFF_F000;
        set_config(10, 200, 1, 30, 500, 2);
        run_random_phase(200, 15);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 3; p++) begin
            set_config($urandom_range(0, 25), $urandom_range(0, 300),
                       bit'($urandom_range(0, 1)),
                       $urandom_range(0, 80), $urandom_range(0, 1500), $urandom_range(0, 5));
            run_random_phase(80, 20);
        end
    endtask

    task automatic test_output_stall();
        drain();
        jitter_on = 1'b0;
        sink_hold_req = 400;
        run_random_phase(40, 15);
        drain();
        jitter_on = 1'b1;
    endtask

    initial begin
        reset_shadow();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_register_masks();
        test_polarity_live();
        test_random_typical();
        test_register_extremes();
        test_time_wrap();
        test_random_settings();
        test_output_stall();
        drain();
        $display("Covered %0d samples and %0d result beats over 12 register settings.",
                 n_samples, n_results);
        $display("Events seen: %0d short, %0d long, %0d rate-limited.", n_short, n_long, n_supp);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> button_press_classifier_top.f
rtl/bpc_pkg.sv
rtl/bpc_ram.sv
rtl/bpc_pipe.sv
rtl/bpc_outq.sv
rtl/button_press_classifier_top.sv
tb/sv/tb_button_press_classifier_top.sv
